// ----- src/sbc_pkg.sv -----
// Shared types and constants for the sector block cache tag controller.
package sbc_pkg;
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int BLOCK_BYTES = 512;
    localparam int BOFF_W = $clog2(BLOCK_BYTES);
    localparam int MAX_REQUEST_BYTES = 4096;
    localparam int PREFETCH_BYTES = 131072;
    localparam int CNT_W = 13;
    localparam int BLK_W = 23;
    localparam int SRC_W = 17;
    localparam int WIN_W = 18;

    localparam logic [1:0] K_PREFETCH = 2'd0;
    localparam logic [1:0] K_COPY     = 2'd1;
    localparam logic [1:0] K_FETCH    = 2'd2;
    localparam logic [1:0] K_SHORT    = 2'd3;

    localparam logic CMD_READ = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [1:0]  op;        // OP_* code
        logic [31:0] offset;
        logic [CNT_W-1:0] count;
        logic        inval;     // clear all tags first
        logic        fill_ok;
    } t_cmd;

    localparam logic [1:0] OP_SHORT0    = 2'd0; // zero count
    localparam logic [1:0] OP_PREFETCH  = 2'd1;
    localparam logic [1:0] OP_WALK      = 2'd2;
    localparam logic [1:0] OP_FILL      = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0] fetch_block;
        logic [SRC_W-1:0] source_offset;
        logic [CNT_W-1:0] dest_offset;
        logic [CNT_W-1:0] length;
        logic [CNT_W-1:0] delivered;
        logic             last;
    } t_res;
endpackage

// ----- src/sector_block_cache_round_robin_top.sv -----
// Top level of the sector block cache tag controller.
// Input channel: i_valid / o_stall with per-field ports; command 0 is a read
// request, command 1 a fill reply for the outstanding fetch.
// Output channel: o_valid / i_stall, one result item per handshake.
// Config: i_cfg_we / i_cfg_data write the prefetch window (bytes).
// An accepted item sits in the front classifier register until the back
// walker takes it. A short or prefetch result is loaded into the output
// register as the walker takes the item. A walk presents its pieces one per
// cycle while the receiver does not stall; the walker looks up one block per
// cycle and takes the next item only once the walk is done.
// A miss ends the walk with a fetch result; the walk resumes if the next fill
// reply is good, and a failed one ends it with a short result. A new request drops any outstanding fetch.
// Reset (synchronous, active low) clears all tags, the replacement pointer,
// file binding and window. When the receiver stalls the result holds in the
// output register and the walker and then the front stall in turn.
module sector_block_cache_round_robin_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [15:0] i_file_handle,
    input  logic [31:0] i_file_size,
    input  logic [31:0] i_byte_offset,
    input  logic [12:0] i_byte_count,
    input  logic        i_fill_ok,
    input  logic        i_cfg_we,
    input  logic [17:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [5:0]  o_slot,
    output logic [22:0] o_fetch_block,
    output logic [16:0] o_source_offset,
    output logic [12:0] o_dest_offset,
    output logic [12:0] o_length,
    output logic [12:0] o_delivered,
    output logic        o_last
);
    import sbc_pkg::*;

    logic q_valid, q_stall;
    t_cmd q_cmd;
    t_res res;

    sbc_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_file_handle,
        .i_file_size, .i_byte_offset, .i_byte_count, .i_fill_ok, .i_cfg_we,
        .i_cfg_data, .o_q_valid(q_valid), .i_q_stall(q_stall), .o_q_cmd(q_cmd)
    );

    sbc_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_stall(q_stall),
        .i_q_cmd(q_cmd), .o_valid, .i_stall, .o_res(res)
    );

    assign o_kind = res.kind;
    assign o_slot = res.slot;
    assign o_fetch_block = res.fetch_block;
    assign o_source_offset = res.source_offset;
    assign o_dest_offset = res.dest_offset;
    assign o_length = res.length;
    assign o_delivered = res.delivered;
    assign o_last = res.last;
endmodule

// ----- src/sbc_front.sv -----
// Front end: accepts items, checks count, file binding and prefetch window.
module sbc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_command,
    input  logic [15:0]       i_file_handle,
    input  logic [31:0]       i_file_size,
    input  logic [31:0]       i_byte_offset,
    input  logic [12:0]       i_byte_count,
    input  logic              i_fill_ok,
    input  logic              i_cfg_we,
    input  logic [17:0]       i_cfg_data,
    output logic              o_q_valid,
    input  logic              i_q_stall,
    output sbc_pkg::t_cmd     o_q_cmd
);
    import sbc_pkg::*;

    logic [15:0]      r_fid;
    logic [31:0]      r_fsize;
    logic [WIN_W-1:0] r_window;
    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic [CNT_W-1:0] sat_cnt;
    logic [WIN_W-1:0] win;
    logic [32:0]      end_pos;
    logic             accept;

    assign o_stall = r_valid && i_q_stall;
    assign accept = i_valid && !o_stall;
    assign sat_cnt = (i_byte_count > CNT_W'(MAX_REQUEST_BYTES)) ?
                     CNT_W'(MAX_REQUEST_BYTES) : i_byte_count;
    assign win = (r_window > WIN_W'(PREFETCH_BYTES)) ? WIN_W'(PREFETCH_BYTES) : r_window;
    assign end_pos = {1'b0, i_byte_offset} + 33'(sat_cnt);

    always_comb begin
        n_cmd = '0;
        n_cmd.offset = i_byte_offset;
        n_cmd.count = sat_cnt;
        n_cmd.fill_ok = i_fill_ok;
        if (i_command == CMD_FILL) begin
            n_cmd.op = OP_FILL;
        end else if (i_byte_count == '0) begin
            n_cmd.op = OP_SHORT0;
        end else begin
            n_cmd.inval = (i_file_handle != r_fid) || (i_file_size != r_fsize);
            if (win != '0 && end_pos <= 33'(win)) n_cmd.op = OP_PREFETCH;
            else n_cmd.op = OP_WALK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fid <= '0;
            r_fsize <= '0;
            r_window <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_window <= i_cfg_data;
            if (accept) begin
                r_valid <= 1'b1;
                if (i_command == CMD_READ && i_byte_count != '0) begin
                    r_fid <= i_file_handle;
                    r_fsize <= i_file_size;
                end
            end else if (!i_q_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_cmd <= n_cmd;
    end

    assign o_q_valid = r_valid;
    assign o_q_cmd = r_cmd;
endmodule

// ----- src/sbc_back.sv -----
// Back end: tag walk, round-robin allocation and result output register.
module sbc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_stall,
    input  sbc_pkg::t_cmd     i_q_cmd,
    output logic              o_valid,
    input  logic              i_stall,
    output sbc_pkg::t_res     o_res
);
    import sbc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;

    logic [1:0]            r_state;
    logic [BLK_W-1:0]      r_tag [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_tvalid;
    logic [SLOT_W-1:0]     r_ptr;
    logic                  r_pend;
    logic [31:0]           r_pos;
    logic [CNT_W-1:0]      r_rem;
    logic [CNT_W-1:0]      r_tot;
    logic [SLOT_W-1:0]     r_pslot;
    logic                  r_ovalid;
    t_res                  r_res;

    logic                  out_free;
    logic                  take;
    logic                  emit;
    logic [BLK_W-1:0]      cur_blk;
    logic [BOFF_W-1:0]     cur_off;
    logic [CNT_W-1:0]      can;
    logic                  hit;
    logic [SLOT_W-1:0]     hit_idx;

    assign out_free = !r_ovalid || !i_stall;
    assign take = i_q_valid && r_state == S_IDLE && out_free;
    assign o_q_stall = !(r_state == S_IDLE && out_free);

    // a result item is loaded into the output register this cycle
    assign emit = (take && (i_q_cmd.op == OP_SHORT0 || i_q_cmd.op == OP_PREFETCH ||
                            (i_q_cmd.op == OP_FILL && r_pend && !i_q_cmd.fill_ok))) ||
                  (r_state == S_WALK && r_rem != '0 && out_free);

    assign cur_blk = BLK_W'(r_pos >> BOFF_W);
    assign cur_off = r_pos[BOFF_W-1:0];

    always_comb begin
        logic [CNT_W-1:0] room;
        room = CNT_W'(BLOCK_BYTES) - CNT_W'(cur_off);
        can = (room > r_rem) ? r_rem : room;
    end

    // lowest matching valid slot
    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_tvalid[i] && r_tag[i] == cur_blk) begin
                hit = 1'b1;
                hit_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tvalid <= '0;
            r_ptr <= '0;
            r_pend <= 1'b0;
            r_pos <= '0;
            r_rem <= '0;
            r_tot <= '0;
            r_pslot <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_free) r_ovalid <= emit;
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        unique case (i_q_cmd.op)
                            OP_SHORT0: begin
                                r_pend <= 1'b0;
                                r_res <= '{kind: K_SHORT, last: 1'b1, default: '0};
                            end
                            OP_PREFETCH: begin
                                r_pend <= 1'b0;
                                if (i_q_cmd.inval) r_tvalid <= '0;
                                r_res <= '{kind: K_PREFETCH,
                                           source_offset: SRC_W'(i_q_cmd.offset),
                                           length: i_q_cmd.count,
                                           delivered: i_q_cmd.count,
                                           last: 1'b1, default: '0};
                            end
                            OP_WALK: begin
                                r_pend <= 1'b0;
                                if (i_q_cmd.inval) r_tvalid <= '0;
                                r_pos <= i_q_cmd.offset;
                                r_rem <= i_q_cmd.count;
                                r_tot <= '0;
                                r_state <= S_WALK;
                            end
                            OP_FILL: begin
                                if (r_pend) begin
                                    r_pend <= 1'b0;
                                    if (!i_q_cmd.fill_ok) begin
                                        r_res <= '{kind: K_SHORT, delivered: r_tot,
                                                   last: 1'b1, default: '0};
                                    end else begin
                                        r_tag[r_pslot] <= cur_blk;
                                        r_tvalid[r_pslot] <= 1'b1;
                                        r_state <= S_WALK;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    if (r_rem == '0) begin
                        r_state <= S_IDLE;
                    end else if (out_free) begin
                        if (hit) begin
                            r_res <= '{kind: K_COPY, slot: hit_idx,
                                       source_offset: SRC_W'(cur_off),
                                       dest_offset: r_tot, length: can,
                                       delivered: r_tot + can,
                                       last: (can == r_rem), default: '0};
                            r_tot <= r_tot + can;
                            r_rem <= r_rem - can;
                            r_pos <= r_pos + 32'(can);
                            if (can == r_rem) r_state <= S_IDLE;
                        end else begin
                            r_res <= '{kind: K_FETCH, slot: r_ptr, fetch_block: cur_blk,
                                       dest_offset: r_tot, delivered: r_tot,
                                       default: '0};
                            r_tvalid[r_ptr] <= 1'b0;
                            r_pslot <= r_ptr;
                            r_ptr <= r_ptr + 1'b1;
                            r_pend <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_res = r_res;

    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK |-> !r_pend) else $error("pending during walk");
    a_fetch_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && out_free && r_rem != '0 && !hit) |=> r_pend)
        else $error("fetch without pending");
    a_ptr_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && out_free && r_rem != '0 && !hit) |=>
        r_ptr == $past(r_ptr) + 1'b1) else $error("pointer not advanced");
endmodule

// ----- dv/tb_sector_block_cache_round_robin_top.sv -----
// Testbench for the sector block cache tag controller: predictor scoreboard, directed and random traffic.
`timescale 1ns / 100ps

module tb_sector_block_cache_round_robin_top;
    import sbc_pkg::*;

    class cache_tag_scoreboard;
        bit [BLK_W-1:0]  tag_blk [SLOT_COUNT];
        bit              tag_v [SLOT_COUNT];
        bit [SLOT_W-1:0] rr_ptr;
        bit [15:0]       bound_fid;
        bit [31:0]       bound_size;
        bit              pend;
        bit [31:0]       pos;
        bit [CNT_W-1:0]  remain;
        bit [CNT_W-1:0]  total;
        bit [SLOT_W-1:0] pslot;
        bit [WIN_W-1:0]  window;
        t_res            exp_results[$];
        int              errors;

        function void push(logic [1:0] k, int unsigned s, int unsigned b, int unsigned src,
                           int unsigned dst, int unsigned len, int unsigned tot, bit lst);
            t_res r;
            r.kind = k;
            r.slot = s[SLOT_W-1:0];
            r.fetch_block = b[BLK_W-1:0];
            r.source_offset = src[SRC_W-1:0];
            r.dest_offset = dst[CNT_W-1:0];
            r.length = len[CNT_W-1:0];
            r.delivered = tot[CNT_W-1:0];
            r.last = lst;
            exp_results.push_back(r);
        endfunction

        function void walk_blocks();
            bit [BLK_W-1:0] blk;
            int unsigned boff, can;
            int hit;
            while (remain > 0) begin
                blk = pos[31:BOFF_W];
                boff = 32'(pos[BOFF_W-1:0]);
                can = BLOCK_BYTES - boff;
                if (can > 32'(remain)) can = 32'(remain);
                hit = -1;
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (hit < 0 && tag_v[i] && tag_blk[i] == blk) hit = i;
                if (hit < 0) begin
                    pslot = rr_ptr;
                    rr_ptr = rr_ptr + 1'b1;
                    tag_v[pslot] = 0;
                    pend = 1;
                    push(K_FETCH, 32'(pslot), 32'(blk), 0, 32'(total), 0, 32'(total), 0);
                    return;
                end
                push(K_COPY, hit, 0, boff, 32'(total), can, 32'(total) + can,
                     can == 32'(remain));
                total = total + CNT_W'(can);
                remain = remain - CNT_W'(can);
                pos = pos + can;
            end
            pend = 0;
        endfunction

        function void note_item(bit cmd, bit [15:0] fid, bit [31:0] fsize, bit [31:0] off,
                                bit [12:0] cnt, bit ok);
            int unsigned c, w;
            if (cmd == CMD_FILL) begin
                if (!pend) return;
                pend = 0;
                if (!ok) begin
                    push(K_SHORT, 0, 0, 0, 0, 0, 32'(total), 1);
                    return;
                end
                tag_blk[pslot] = pos[31:BOFF_W];
                tag_v[pslot] = 1;
                walk_blocks();
                return;
            end
            pend = 0;
            if (cnt == 0) begin
                push(K_SHORT, 0, 0, 0, 0, 0, 0, 1);
                return;
            end
            c = (cnt > 13'(MAX_REQUEST_BYTES)) ? 32'(MAX_REQUEST_BYTES) : 32'(cnt);
            if (fid != bound_fid || fsize != bound_size) begin
                bound_fid = fid;
                bound_size = fsize;
                foreach (tag_v[i]) tag_v[i] = 0;
            end
            w = (32'(window) > 32'(PREFETCH_BYTES)) ? 32'(PREFETCH_BYTES) : 32'(window);
            if (w != 0 && ({1'b0, off} + 33'(c)) <= 33'(w)) begin
                push(K_PREFETCH, 0, 0, off, 0, c, c, 1);
                return;
            end
            pos = off;
            remain = CNT_W'(c);
            total = 0;
            walk_blocks();
        endfunction

        function void cmp(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $error("%s mismatch: expected %0d actual %0d", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_res act);
            t_res e;
            if (exp_results.size() == 0) begin
                $error("unexpected result item kind %0d", act.kind);
                errors++;
                return;
            end
            e = exp_results.pop_front();
            cmp("kind", e.kind, act.kind);
            cmp("slot", e.slot, act.slot);
            cmp("fetch_block", e.fetch_block, act.fetch_block);
            cmp("source_offset", e.source_offset, act.source_offset);
            cmp("dest_offset", e.dest_offset, act.dest_offset);
            cmp("length", e.length, act.length);
            cmp("delivered", e.delivered, act.delivered);
            cmp("last", e.last, act.last);
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic        i_command = 0;
    logic [15:0] i_file_handle = 0;
    logic [31:0] i_file_size = 0;
    logic [31:0] i_byte_offset = 0;
    logic [12:0] i_byte_count = 0;
    logic        i_fill_ok = 0;
    logic        i_cfg_we = 0;
    logic [17:0] i_cfg_data = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [1:0]  o_kind;
    logic [5:0]  o_slot;
    logic [22:0] o_fetch_block;
    logic [16:0] o_source_offset;
    logic [12:0] o_dest_offset;
    logic [12:0] o_length;
    logic [12:0] o_delivered;
    logic        o_last;

    sector_block_cache_round_robin_top uut (.*);

    cache_tag_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit [15:0] cur_fid = 16'h0001;
    bit [31:0] cur_size = 32'd100000;

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < rx_stall_pct);

    always @(posedge i_clk) begin
        t_res r;
        if (i_rst_n && o_valid && !i_stall) begin
            r.kind = o_kind;
            r.slot = o_slot;
            r.fetch_block = o_fetch_block;
            r.source_offset = o_source_offset;
            r.dest_offset = o_dest_offset;
            r.length = o_length;
            r.delivered = o_delivered;
            r.last = o_last;
            sb.check_result(r);
        end
    end

    // Called at a falling edge; returns at a falling edge after acceptance and any random idle gap.
    task send_item(bit cmd, bit [15:0] fid, bit [31:0] fsize, bit [31:0] off,
                   bit [12:0] cnt, bit ok);
        i_valid = 1;
        i_command = cmd;
        i_file_handle = fid;
        i_file_size = fsize;
        i_byte_offset = off;
        i_byte_count = cnt;
        i_fill_ok = ok;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_item(cmd, fid, fsize, off, cnt, ok);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 0;
            @(negedge i_clk);
        end
    endtask

    task read_req(bit [31:0] off, bit [12:0] cnt);
        send_item(CMD_READ, cur_fid, cur_size, off, cnt, 1'($urandom_range(1)));
    endtask

    task fill(bit ok);
        send_item(CMD_FILL, 16'($urandom), $urandom, $urandom, 13'($urandom), ok);
    endtask

    // Drain all results, let the pipeline settle, then write the window.
    task write_window(bit [17:0] v);
        i_valid = 0;
        while (sb.exp_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we = 1;
        i_cfg_data = v;
        @(negedge i_clk);
        i_cfg_we = 0;
        sb.window = v;
    endtask

    task random_item();
        bit [31:0] off;
        bit [12:0] cnt;
        int sel;
        if (sb.pend && $urandom_range(99) < 80) begin
            fill($urandom_range(99) < 88);
            return;
        end
        if ($urandom_range(99) < 4) begin
            fill(1'($urandom_range(1)));
            return;
        end
        sel = $urandom_range(99);
        if (sel < 6) cur_fid = 16'($urandom);
        else if (sel < 9) cur_size = $urandom;
        sel = $urandom_range(99);
        if (sel < 65) off = $urandom_range(0, 12 * BLOCK_BYTES);
        else if (sel < 80) off = $urandom_range(0, 140000);
        else if (sel < 90) off = $urandom;
        else off = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        sel = $urandom_range(99);
        if (sel < 5) cnt = 0;
        else if (sel < 12) cnt = 13'($urandom_range(4097, 8191));
        else if (sel < 18) cnt = 13'd4096;
        else if (sel < 60) cnt = 13'($urandom_range(1, 600));
        else cnt = 13'($urandom_range(1, 1800));
        read_req(off, cnt);
    endtask

    initial begin
        bit [17:0] windows [8];
        windows = '{18'h3FFFF, 18'd0, 18'd131072, 18'd5000,
                    18'd1, 18'd131071, 18'd0, 18'd0};
        windows[7] = 18'($urandom);
        repeat (2) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // directed: window disabled
        read_req(32'd40, 13'd0);
        read_req(32'd0, 13'd100);
        fill(1);
        read_req(32'd10, 13'd50);
        read_req(32'd1000, 13'd1500);
        fill(1);
        fill(1);
        fill(1);
        read_req(32'd3000, 13'd600);
        fill(0);
        fill(1);
        read_req(32'hFFFF_FF00, 13'd8191);
        fill(1);
        fill(1);
        read_req(32'd7000, 13'd20);
        cur_fid = 16'hFFFF;
        cur_size = 32'hFFFF_FFFF;
        read_req(32'd0, 13'd100);
        fill(1);
        write_window(18'd131072);
        read_req(32'd0, 13'd4096);
        read_req(32'd131062, 13'd10);
        read_req(32'd131062, 13'd11);
        fill(1);
        read_req(32'd130000, 13'd8191);

        for (int ph = 0; ph < 8; ph++) begin
            write_window(windows[ph]);
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin tx_idle_pct = 27; rx_stall_pct = 27; end
            endcase
            for (int n = 0; n < 48; n++) random_item();
        end

        i_valid = 0;
        while (sb.exp_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (sb.errors == 0 && sb.exp_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
src/sbc_pkg.sv
src/sbc_front.sv
src/sbc_back.sv
src/sector_block_cache_round_robin_top.sv
dv/tb_sector_block_cache_round_robin_top.sv
